@@ design/fir_filter_convolution_defines.svh @@
// Assertion helpers used by the filter sequencer.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef FIR_FILTER_CONVOLUTION_DEFINES_SVH
`define FIR_FILTER_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCV_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir_conv: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FCV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir_conv: next-cycle check failed");

`endif

@@ design/fir_conv_pkg.sv @@
`timescale 1ns / 1ps

package fir_conv_pkg;

    // Fixed field widths and number formats.
    localparam int SAMPLE_W    = 16;
    localparam int COEFF_W     = 16;
    localparam int COEFF_FRAC  = 15;
    localparam int INDEX_W     = 4;
    localparam int TAP_COUNT_W = 5;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 5'd16;

    // Operation codes of an input word.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_TAP_COUNT = 1'b0;

    typedef struct packed {
        logic                       op;
        logic [INDEX_W-1:0]         coeff_index;
        logic signed [COEFF_W-1:0]  coeff_value;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_block;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result;
        logic                       last;
        logic                       overflow;
    } res_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Controls from the sequencer to the memories.
    typedef struct packed {
        logic dl_write;
        logic dl_drop;
        logic dl_clear;
        logic rd_en;
    } st_ctrl_t;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic prod_en;
        logic acc_clear;
        logic acc_en;
    } mac_ctrl_t;

endpackage

@@ design/fir_conv_store.sv @@
`timescale 1ns / 1ps

module fir_conv_store #(
    parameter int TAPS  = 16,
    parameter int IDX_W = 4
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  fir_conv_pkg::st_ctrl_t                     ctrl,
    input  logic                                       coeff_we,
    input  logic [IDX_W-1:0]                           coeff_waddr,
    input  logic signed [fir_conv_pkg::COEFF_W-1:0]    coeff_wdata,
    input  logic [IDX_W-1:0]                           dl_waddr,
    input  logic signed [fir_conv_pkg::SAMPLE_W-1:0]   dl_wdata,
    input  logic [IDX_W-1:0]                           rd_coeff_addr,
    input  logic [IDX_W-1:0]                           rd_dl_addr,
    output logic signed [fir_conv_pkg::COEFF_W-1:0]    coeff_rdata,
    output logic signed [fir_conv_pkg::SAMPLE_W-1:0]   dl_rdata
);
    import fir_conv_pkg::*;

    logic signed [COEFF_W-1:0]  coeff_mem [TAPS];
    logic signed [SAMPLE_W-1:0] dl_mem    [TAPS];
    logic [TAPS-1:0]            valid_reg;

    logic signed [COEFF_W-1:0]  coeff_rd_reg;
    logic signed [SAMPLE_W-1:0] dl_rd_reg;
    logic                       vbit_rd_reg;

    // Coefficient memory write port.
    always_ff @(posedge clk)
    begin
        if (coeff_we)
        begin
            coeff_mem[coeff_waddr] <= coeff_wdata;
        end
    end

    // Delay line memory write port.
    always_ff @(posedge clk)
    begin
        if (ctrl.dl_write)
        begin
            dl_mem[dl_waddr] <= dl_wdata;
        end
    end

    // Per-entry valid bits; an invalid entry reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.dl_clear)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.dl_write)
        begin
            valid_reg[dl_waddr] <= 1'b1;
        end
        else if (ctrl.dl_drop)
        begin
            valid_reg[dl_waddr] <= 1'b0;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            coeff_rd_reg <= coeff_mem[rd_coeff_addr];
            dl_rd_reg    <= dl_mem[rd_dl_addr];
            vbit_rd_reg  <= valid_reg[rd_dl_addr];
        end
    end

    assign coeff_rdata = coeff_rd_reg;
    assign dl_rdata    = vbit_rd_reg ? dl_rd_reg : '0;

endmodule

@@ design/fir_conv_mac.sv @@
`timescale 1ns / 1ps

module fir_conv_mac #(
    parameter int TAPS = 16
) (
    input  logic                                       clk,
    input  fir_conv_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [fir_conv_pkg::COEFF_W-1:0]    coeff,
    input  logic signed [fir_conv_pkg::SAMPLE_W-1:0]   data,
    output logic signed [fir_conv_pkg::SAMPLE_W-1:0]   result,
    output logic                                       overflow
);
    import fir_conv_pkg::*;

    localparam int PROD_W = COEFF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEFF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] MAX_OUT    = (ACC_W'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] MIN_OUT    = -MAX_OUT - 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  scaled;

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= coeff * data;
        end
    end

    // Accumulator, cleared at the start of every output word.
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up, drop the fraction, then saturate to the sample range.
    always_comb
    begin
        rounded  = acc_reg + ROUND_HALF;
        scaled   = rounded >>> COEFF_FRAC;
        overflow = 1'b0;
        result   = scaled[SAMPLE_W-1:0];
        if (scaled > MAX_OUT)
        begin
            result   = MAX_OUT[SAMPLE_W-1:0];
            overflow = 1'b1;
        end
        else if (scaled < MIN_OUT)
        begin
            result   = MIN_OUT[SAMPLE_W-1:0];
            overflow = 1'b1;
        end
    end

endmodule

@@ design/fir_conv_seq.sv @@
`timescale 1ns / 1ps
`include "fir_filter_convolution_defines.svh"

module fir_conv_seq #(
    parameter int TAPS  = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  fir_conv_pkg::item_t                         item,
    input  logic                                        item_valid,
    output logic                                        item_ready,
    input  logic [fir_conv_pkg::TAP_COUNT_W-1:0]        tap_count,
    input  logic                                        out_free,
    output logic                                        out_load,
    output logic                                        out_last,
    output fir_conv_pkg::st_ctrl_t                      st_ctrl,
    output fir_conv_pkg::mac_ctrl_t                     mac_ctrl,
    output logic                                        coeff_we,
    output logic [IDX_W-1:0]                            coeff_waddr,
    output logic [IDX_W-1:0]                            dl_waddr,
    output logic [IDX_W-1:0]                            rd_coeff_addr,
    output logic [IDX_W-1:0]                            rd_dl_addr
);
    import fir_conv_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

    seq_state_t       state_reg,   state_next;
    logic [IDX_W-1:0] wp_reg,      wp_next;
    logic [IDX_W-1:0] rp_reg,      rp_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [CNT_W-1:0] n_reg,       n_next;
    logic             eob_reg,     eob_next;
    logic             s1_vld_reg,  s1_vld_next;
    logic             s1_last_reg, s1_last_next;
    logic             s2_vld_reg,  s2_vld_next;
    logic             s2_last_reg, s2_last_next;

    logic             accept;
    logic [IDX_W-1:0] wp_inc;
    logic [IDX_W-1:0] rp_dec;
    logic [CNT_W-1:0] n_eff;
    logic             final_out;

    // Circular pointer steps and the clamped tap count.
    always_comb
    begin
        wp_inc = (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
        rp_dec = (rp_reg == '0) ? LAST_IDX : rp_reg - IDX_W'(1);
        if (tap_count == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(tap_count) > TAPS)
        begin
            n_eff = CNT_W'(TAPS);
        end
        else
        begin
            n_eff = CNT_W'(tap_count);
        end
    end

    assign accept    = item_valid && item_ready;
    assign final_out = (out_cnt_reg + CNT_W'(1)) == n_reg;

    // State and pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            iss_cnt_reg <= '0;
            out_cnt_reg <= '0;
            n_reg       <= CNT_W'(1);
            eob_reg     <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            iss_cnt_reg <= iss_cnt_next;
            out_cnt_reg <= out_cnt_next;
            n_reg       <= n_next;
            eob_reg     <= eob_next;
            s1_vld_reg  <= s1_vld_next;
            s1_last_reg <= s1_last_next;
            s2_vld_reg  <= s2_vld_next;
            s2_last_reg <= s2_last_next;
        end
    end

    // Next state and controls.
    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        iss_cnt_next = iss_cnt_reg;
        out_cnt_next = out_cnt_reg;
        n_next       = n_reg;
        eob_next     = eob_reg;
        s1_vld_next  = 1'b0;
        s1_last_next = 1'b0;
        s2_vld_next  = s1_vld_reg;
        s2_last_next = s1_last_reg;

        item_ready    = 1'b0;
        out_load      = 1'b0;
        out_last      = eob_reg && final_out;
        st_ctrl       = '0;
        mac_ctrl      = '0;
        coeff_we      = 1'b0;
        coeff_waddr   = IDX_W'(item.coeff_index);
        dl_waddr      = wp_inc;
        rd_coeff_addr = iss_cnt_reg[IDX_W-1:0];
        rd_dl_addr    = rp_reg;

        mac_ctrl.prod_en = s1_vld_reg;
        mac_ctrl.acc_en  = s2_vld_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        coeff_we = 32'(item.coeff_index) < TAPS;
                    end
                    else
                    begin
                        // Newest sample goes one slot past the write pointer.
                        st_ctrl.dl_write   = 1'b1;
                        wp_next            = wp_inc;
                        rp_next            = wp_inc;
                        n_next             = n_eff;
                        eob_next           = item.end_of_block;
                        iss_cnt_next       = '0;
                        out_cnt_next       = '0;
                        mac_ctrl.acc_clear = 1'b1;
                        state_next         = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                // Issue one tap per cycle, walking back from the newest sample.
                if (iss_cnt_reg != n_reg)
                begin
                    st_ctrl.rd_en = 1'b1;
                    s1_vld_next   = 1'b1;
                    s1_last_next  = (iss_cnt_reg + CNT_W'(1)) == n_reg;
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    rp_next       = rp_dec;
                end
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (eob_reg && !final_out)
                    begin
                        // Tail: shift a zero in by invalidating the next slot.
                        st_ctrl.dl_drop    = 1'b1;
                        wp_next            = wp_inc;
                        rp_next            = wp_inc;
                        iss_cnt_next       = '0;
                        out_cnt_next       = out_cnt_reg + CNT_W'(1);
                        mac_ctrl.acc_clear = 1'b1;
                        state_next         = ST_RUN;
                    end
                    else
                    begin
                        st_ctrl.dl_clear = eob_reg;
                        state_next       = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FCV_ASSERT_IMPL(a_idle_pipe_empty, state_reg == ST_IDLE, !s1_vld_reg && !s2_vld_reg)
    `FCV_ASSERT_IMPL(a_counts_bounded, state_reg != ST_IDLE, (iss_cnt_reg <= n_reg) && (out_cnt_reg < n_reg))
    `FCV_ASSERT_IMPL(a_last_needs_eob, out_load && out_last, eob_reg)
    `FCV_ASSERT_NEXT(a_drain_to_done, (state_reg == ST_RUN) && s2_vld_reg && s2_last_reg, state_reg == ST_DONE)

endmodule

@@ design/fir_filter_convolution.sv @@
`timescale 1ns / 1ps

// Direct-form FIR filter over up to TAPS coefficients. An input word either
// loads one Q1.15 coefficient or filters one Q15 sample. A sample gives one
// output word; with end_of_block set it is followed by n - 1 tail words, n
// being tap_count clamped to 1..TAPS, the last one flagged, after which the
// delay line reads as zero again. The time per output is set by the single
// shared multiply-accumulate unit, which takes one tap per cycle from one
// read port of the coefficient memory and one of the delay line memory, plus
// the memory read and product registers. Results are rounded half up and
// saturated, with overflow marking a clipped word. Every coefficient in use
// must be loaded before samples are filtered. tap_count is written through
// the APB port at byte address 0; the user must write it only while the
// block is idle, which the block itself does not enforce.
module fir_filter_convolution #(
    parameter int TAPS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    input  fir_conv_pkg::item_t                     item,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    output fir_conv_pkg::res_t                      res,
    output logic                                    res_valid,
    input  logic                                    res_ready
);
    import fir_conv_pkg::*;

    localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = $clog2(TAPS + 1);

    logic [TAP_COUNT_W-1:0]     tap_count_reg;
    res_t                       res_reg;
    logic                       res_valid_reg;

    st_ctrl_t                   st_ctrl;
    mac_ctrl_t                  mac_ctrl;
    logic                       coeff_we;
    logic [IDX_W-1:0]           coeff_waddr;
    logic [IDX_W-1:0]           dl_waddr;
    logic [IDX_W-1:0]           rd_coeff_addr;
    logic [IDX_W-1:0]           rd_dl_addr;
    logic signed [COEFF_W-1:0]  coeff_rdata;
    logic signed [SAMPLE_W-1:0] dl_rdata;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       mac_overflow;
    logic                       out_free;
    logic                       out_load;
    logic                       out_last;
    logic                       cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            tap_count_reg <= pwdata[TAP_COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TAP_COUNT)
        begin
            prdata = 32'(tap_count_reg);
        end
    end

    fir_conv_seq #(
        .TAPS  (TAPS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .tap_count     (tap_count_reg),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_last      (out_last),
        .st_ctrl       (st_ctrl),
        .mac_ctrl      (mac_ctrl),
        .coeff_we      (coeff_we),
        .coeff_waddr   (coeff_waddr),
        .dl_waddr      (dl_waddr),
        .rd_coeff_addr (rd_coeff_addr),
        .rd_dl_addr    (rd_dl_addr)
    );

    fir_conv_store #(
        .TAPS  (TAPS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (st_ctrl),
        .coeff_we      (coeff_we),
        .coeff_waddr   (coeff_waddr),
        .coeff_wdata   (item.coeff_value),
        .dl_waddr      (dl_waddr),
        .dl_wdata      (item.sample),
        .rd_coeff_addr (rd_coeff_addr),
        .rd_dl_addr    (rd_dl_addr),
        .coeff_rdata   (coeff_rdata),
        .dl_rdata      (dl_rdata)
    );

    fir_conv_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .coeff    (coeff_rdata),
        .data     (dl_rdata),
        .result   (mac_result),
        .overflow (mac_overflow)
    );

    // Output register; a finished word waits here while the next item is taken.
    assign out_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg.result   <= mac_result;
            res_reg.last     <= out_last;
            res_reg.overflow <= mac_overflow;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule
